FILE: sv/mlc_pkg.sv
`timescale 1ns / 1ps

package mlc_pkg;

  // Default group size of the matrix.
  localparam int DEF_MAX_NODES = 8;

  // Width of one matrix entry.
  localparam int VAL_W = 31;

  // Reset values of the configuration registers.
  localparam logic [3:0] NODE_COUNT_RST = 4'd8;
  localparam logic [2:0] OWN_ID_RST     = 3'd0;

  // Configuration register indexes.
  localparam logic CFG_NODE_COUNT = 1'b0;
  localparam logic CFG_OWN_ID     = 1'b1;

  // Operation codes carried in the func field.
  typedef enum logic [2:0] {
    OP_TICK  = 3'd0,
    OP_RESET = 3'd1,
    OP_SET   = 3'd2,
    OP_MERGE = 3'd3,
    OP_READ  = 3'd4
  } op_t;

  // One input item.
  typedef struct packed {
    logic [2:0]       func;
    logic [2:0]       row_index;
    logic [2:0]       col_index;
    logic [VAL_W-1:0] value;
    logic             last_cell;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [VAL_W-1:0] read_value;
    logic             status;
  } out_item_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_UPDATE,
    S_FOLD_RD,
    S_FOLD_CMP,
    S_FINISH
  } state_t;

  // Read address selection.
  typedef enum logic [1:0] {
    RD_ITEM,
    RD_OWN,
    RD_FOLD
  } rd_src_t;

  // Write address and data selection.
  typedef enum logic [1:0] {
    WR_TICK,
    WR_SET,
    WR_MERGE,
    WR_FOLD
  } wr_src_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    capture;
    logic    rd_req;
    rd_src_t rd_src;
    logic    wr_req;
    wr_src_t wr_src;
    logic    clr_node;
    logic    fold_start;
    logic    fold_step;
    logic    res_read;
    logic    out_load;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [2:0] func;
    logic       last;
    logic       r_ok;
    logic       rc_ok;
    logic       own_ok;
    logic       fold_row_last;
    logic       fold_col_last;
    logic       out_free;
  } dp_stat_t;

endpackage

FILE: sv/matrix_logical_clock_core.sv
`timescale 1ns / 1ps
// A merge with the last-cell mark and an in-range own id adds the own-row fold, which reads
// every active entry in turn through the single memory read port (S_FOLD_RD, S_FOLD_CMP).
// The core takes one item at a time; the next is taken only after the last result is loaded.
// Reset (synchronous): the controller goes idle, all matrix entries read as zero at once
// through per-entry valid bits, node_count becomes 8 and own_id 0.

module matrix_logical_clock_core #(
  parameter int MAX_NODES = mlc_pkg::DEF_MAX_NODES
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  mlc_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output mlc_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [3:0]         cfg_data
);
  import mlc_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer for the operations and the fold walk.
  mlc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Matrix storage, configuration and result registers.
  mlc_datapath #(
    .MAX_NODES (MAX_NODES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

FILE: sv/mlc_ctrl.sv
`timescale 1ns / 1ps

module mlc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  mlc_pkg::dp_stat_t stat,
  output mlc_pkg::dp_cmd_t  cmd
);
  import mlc_pkg::*;

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat.func)
          OP_TICK: state_next = stat.own_ok ? S_UPDATE : S_FINISH;
          OP_MERGE: begin
            if (stat.rc_ok) begin
              state_next = S_UPDATE;
            end else if (stat.last && stat.own_ok) begin
              state_next = S_FOLD_RD;
            end else begin
              state_next = S_FINISH;
            end
          end
          OP_READ: state_next = stat.rc_ok ? S_UPDATE : S_FINISH;
          default: state_next = S_FINISH;
        endcase
      end
      S_UPDATE: begin
        if (stat.func == OP_MERGE && stat.last && stat.own_ok) begin
          state_next = S_FOLD_RD;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_FOLD_RD: state_next = S_FOLD_CMP;
      S_FOLD_CMP: begin
        if (stat.fold_row_last && stat.fold_col_last) begin
          state_next = S_FINISH;
        end else begin
          state_next = S_FOLD_RD;
        end
      end
      S_FINISH: begin
        if (stat.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd          = '0;
    cmd.rd_src   = RD_ITEM;
    cmd.wr_src   = WR_TICK;
    in_stall     = 1'b1;
    case (state)
      S_IDLE: begin
        // No transfer is taken while reset is held.
        in_stall    = rst;
        cmd.capture = in_valid && !rst;
      end
      S_DECODE: begin
        case (stat.func)
          OP_TICK: begin
            cmd.rd_req = stat.own_ok;
            cmd.rd_src = RD_OWN;
          end
          OP_RESET: cmd.clr_node = stat.r_ok;
          OP_SET: begin
            cmd.wr_req = stat.r_ok;
            cmd.wr_src = WR_SET;
          end
          OP_MERGE: begin
            cmd.rd_req     = stat.rc_ok;
            cmd.rd_src     = RD_ITEM;
            cmd.fold_start = !stat.rc_ok && stat.last && stat.own_ok;
          end
          OP_READ: begin
            cmd.rd_req = stat.rc_ok;
            cmd.rd_src = RD_ITEM;
          end
          default: ;
        endcase
      end
      S_UPDATE: begin
        case (stat.func)
          OP_TICK: begin
            cmd.wr_req = 1'b1;
            cmd.wr_src = WR_TICK;
          end
          OP_MERGE: begin
            cmd.wr_req     = 1'b1;
            cmd.wr_src     = WR_MERGE;
            cmd.fold_start = stat.last && stat.own_ok;
          end
          OP_READ: cmd.res_read = 1'b1;
          default: ;
        endcase
      end
      S_FOLD_RD: begin
        cmd.rd_req = 1'b1;
        cmd.rd_src = RD_FOLD;
      end
      S_FOLD_CMP: begin
        cmd.fold_step = 1'b1;
        cmd.wr_req    = stat.fold_row_last;
        cmd.wr_src    = WR_FOLD;
      end
      S_FINISH: cmd.out_load = stat.out_free;
      default: ;
    endcase
  end

endmodule

FILE: sv/mlc_datapath.sv
`timescale 1ns / 1ps

module mlc_datapath #(
  parameter int MAX_NODES = mlc_pkg::DEF_MAX_NODES
) (
  input  logic               clk,
  input  logic               rst,
  input  mlc_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output mlc_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [3:0]         cfg_data,
  input  mlc_pkg::dp_cmd_t   cmd,
  output mlc_pkg::dp_stat_t  stat
);
  import mlc_pkg::*;

  localparam int IDX_W  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int ADDR_W = 2 * IDX_W;
  localparam int DEPTH  = 1 << ADDR_W;
  localparam int CNT_W  = $clog2(MAX_NODES + 1);

  // Configuration registers.
  logic [3:0] node_count;
  logic [2:0] own_id;

  // Latched item.
  logic [2:0]       it_func;
  logic [2:0]       it_r;
  logic [2:0]       it_c;
  logic [VAL_W-1:0] it_v;
  logic             it_last;

  // Matrix storage; an entry whose valid bit is clear reads as zero.
  logic [VAL_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld;
  logic [VAL_W-1:0] rd_data;
  logic             rd_vld;
  logic [VAL_W-1:0] rd_word;

  // Fold counters and running maximum.
  logic [IDX_W-1:0] fi;
  logic [IDX_W-1:0] fj;
  logic [VAL_W-1:0] best;
  logic [VAL_W-1:0] fold_max;

  // Pending result.
  logic [VAL_W-1:0] res_val;
  logic             res_st;

  logic [CNT_W-1:0]  n;
  logic              r_ok;
  logic              c_ok;
  logic              own_ok;
  logic              in_r_ok;
  logic              in_c_ok;
  logic              in_own_ok;
  logic              in_st;
  logic [IDX_W-1:0]  own_idx;
  logic [IDX_W-1:0]  r_idx;
  logic [IDX_W-1:0]  c_idx;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic [VAL_W-1:0]  wr_data;

  // Effective matrix size, clamped to the storage.
  always_comb begin
    if (32'(node_count) > 32'(MAX_NODES)) begin
      n = CNT_W'(MAX_NODES);
    end else begin
      n = CNT_W'(node_count);
    end
  end

  assign r_ok      = 32'(it_r) < 32'(n);
  assign c_ok      = 32'(it_c) < 32'(n);
  assign own_ok    = 32'(own_id) < 32'(n);
  assign in_r_ok   = 32'(in_data.row_index) < 32'(n);
  assign in_c_ok   = 32'(in_data.col_index) < 32'(n);
  assign in_own_ok = own_ok;

  // Status known when the item is taken in; only read data comes later.
  always_comb begin
    case (in_data.func)
      OP_TICK:  in_st = !in_own_ok;
      OP_RESET: in_st = !in_r_ok;
      OP_SET:   in_st = !in_r_ok;
      OP_MERGE: in_st = !(in_r_ok && in_c_ok) || (in_data.last_cell && !in_own_ok);
      OP_READ:  in_st = !(in_r_ok && in_c_ok);
      default:  in_st = 1'b1;
    endcase
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= NODE_COUNT_RST;
      own_id     <= OWN_ID_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NODE_COUNT: node_count <= cfg_data;
        CFG_OWN_ID:     own_id     <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // Item capture and the pending result.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      it_func <= in_data.func;
      it_r    <= in_data.row_index;
      it_c    <= in_data.col_index;
      it_v    <= in_data.value;
      it_last <= in_data.last_cell;
      res_val <= '0;
      res_st  <= in_st;
    end else if (cmd.res_read) begin
      res_val <= rd_word;
    end
  end

  assign own_idx = IDX_W'(own_id);
  assign r_idx   = IDX_W'(it_r);
  assign c_idx   = IDX_W'(it_c);
  assign rd_word = rd_vld ? rd_data : '0;

  // Running maximum of the column being folded.
  always_comb begin
    if (fi == '0 || rd_word > best) begin
      fold_max = rd_word;
    end else begin
      fold_max = best;
    end
  end

  // Read address selection.
  always_comb begin
    case (cmd.rd_src)
      RD_ITEM: rd_addr = {r_idx, c_idx};
      RD_OWN:  rd_addr = {own_idx, own_idx};
      RD_FOLD: rd_addr = {fi, fj};
      default: rd_addr = {r_idx, c_idx};
    endcase
  end

  // Write address and data selection.
  always_comb begin
    case (cmd.wr_src)
      WR_TICK: begin
        wr_addr = {own_idx, own_idx};
        wr_data = (rd_word == {VAL_W{1'b1}}) ? rd_word : rd_word + VAL_W'(1);
      end
      WR_SET: begin
        wr_addr = {r_idx, r_idx};
        wr_data = it_v;
      end
      WR_MERGE: begin
        wr_addr = {r_idx, c_idx};
        wr_data = (it_v > rd_word) ? it_v : rd_word;
      end
      WR_FOLD: begin
        wr_addr = {own_idx, fj};
        wr_data = fold_max;
      end
      default: begin
        wr_addr = {r_idx, c_idx};
        wr_data = it_v;
      end
    endcase
  end

  // Matrix memory with registered read data.
  always_ff @(posedge clk) begin
    if (cmd.wr_req) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_req) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_req) begin
      rd_vld <= vld[rd_addr];
    end
  end

  // Entry valid bits: reset and a node reset clear them, writes set them.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (cmd.clr_node) begin
      for (int a = 0; a < MAX_NODES; a++) begin
        for (int b = 0; b < MAX_NODES; b++) begin
          if ((a == 32'(it_r) && b < 32'(n)) || (b == 32'(it_r) && a < 32'(n))) begin
            vld[{IDX_W'(a), IDX_W'(b)}] <= 1'b0;
          end
        end
      end
    end else if (cmd.wr_req) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  // Fold walk: rows inner, columns outer.
  always_ff @(posedge clk) begin
    if (cmd.fold_start) begin
      fi <= '0;
      fj <= '0;
    end else if (cmd.fold_step) begin
      best <= fold_max;
      if (stat.fold_row_last) begin
        fi <= '0;
        fj <= fj + IDX_W'(1);
      end else begin
        fi <= fi + IDX_W'(1);
      end
    end
  end

  // Output register; a result may wait here while the next item is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.read_value <= res_val;
      out_data.status     <= res_st;
    end
  end

  // Status toward the controller.
  always_comb begin
    stat.func          = it_func;
    stat.last          = it_last;
    stat.r_ok          = r_ok;
    stat.rc_ok         = r_ok && c_ok;
    stat.own_ok        = own_ok;
    stat.fold_row_last = (32'(fi) + 32'd1) == 32'(n);
    stat.fold_col_last = (32'(fj) + 32'd1) == 32'(n);
    stat.out_free      = !out_valid || !out_stall;
  end

endmodule

FILE: bench/matrix_logical_clock_core_tb.sv
`timescale 1ns / 1ps

module matrix_logical_clock_core_tb;
  import mlc_pkg::*;

  localparam int MAX_NODES = DEF_MAX_NODES;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int SETTLE_CYCLES = 8;
  localparam int FINAL_CYCLES = 2 * MAX_NODES * MAX_NODES + 16;
  localparam int PHASE_COUNT = 12;
  localparam int PHASE_ITEMS = 140;
  localparam int EMPTY_PHASE_ITEMS = 40;
  localparam int MAX_REPORTS = 40;

  // Status codes of a result.
  localparam logic ST_DONE    = 1'b0;
  localparam logic ST_IGNORED = 1'b1;

  // Function codes that have no operation behind them.
  localparam logic [2:0] FUNC_SPARE_5 = 3'd5;
  localparam logic [2:0] FUNC_SPARE_7 = 3'd7;

  localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};

  // One row of the directed table: either a register write or an operation.
  typedef struct {
    bit         is_cfg;
    logic       cfg_sel;
    logic [3:0] cfg_val;
    in_item_t   item;
    bit         has_lit;
    out_item_t  lit;
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_item_t  out_data;
  logic       cfg_we = 1'b0;
  logic       cfg_index = CFG_NODE_COUNT;
  logic [3:0] cfg_data = '0;

  // Shadow copy of the clock matrix and the registers.
  logic [VAL_W-1:0] clock_entries [MAX_NODES][MAX_NODES];
  logic [3:0]       node_count_q;
  logic [2:0]       own_id_q;

  out_item_t   pending_results[$];
  bit          lit_valid = 1'b0;
  out_item_t   lit_result = '0;
  out_item_t   next_want;
  out_item_t   predicted;
  int unsigned send_idle_pct = 34;
  int unsigned recv_idle_pct = 75;
  int unsigned items_sent = 0;
  int          error_count = 0;
  int          cycle_count = 0;

  matrix_logical_clock_core #(
    .MAX_NODES(MAX_NODES)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #4 clk = ~clk;

  // Active matrix size; node_count saturates at the group size.
  function automatic int unsigned active_nodes();
    return (node_count_q > MAX_NODES) ? MAX_NODES : node_count_q;
  endfunction

  // Applies one operation to the shadow matrix and returns its result.
  function automatic out_item_t apply_clock_op(in_item_t item);
    out_item_t        res;
    int unsigned      n;
    int unsigned      i;
    int unsigned      j;
    logic [VAL_W-1:0] best;
    res = '0;
    res.status = ST_DONE;
    n = active_nodes();
    case (item.func)
      OP_TICK: begin
        if (own_id_q < n) begin
          if (clock_entries[own_id_q][own_id_q] != VAL_MAX)
            clock_entries[own_id_q][own_id_q] += 1'b1;
        end else begin
          res.status = ST_IGNORED;
        end
      end
      OP_RESET: begin
        if (item.row_index < n) begin
          for (j = 0; j < n; j++) begin
            clock_entries[item.row_index][j] = '0;
            clock_entries[j][item.row_index] = '0;
          end
        end else begin
          res.status = ST_IGNORED;
        end
      end
      OP_SET: begin
        if (item.row_index < n)
          clock_entries[item.row_index][item.row_index] = item.value;
        else
          res.status = ST_IGNORED;
      end
      OP_MERGE: begin
        if (item.row_index < n && item.col_index < n) begin
          if (item.value > clock_entries[item.row_index][item.col_index])
            clock_entries[item.row_index][item.col_index] = item.value;
        end else begin
          res.status = ST_IGNORED;
        end
        // The own-row fold runs on the last cell, even when that cell was dropped.
        if (item.last_cell) begin
          if (own_id_q < n) begin
            for (j = 0; j < n; j++) begin
              best = clock_entries[0][j];
              for (i = 1; i < n; i++)
                if (clock_entries[i][j] > best) best = clock_entries[i][j];
              clock_entries[own_id_q][j] = best;
            end
          end else begin
            res.status = ST_IGNORED;
          end
        end
      end
      OP_READ: begin
        if (item.row_index < n && item.col_index < n)
          res.read_value = clock_entries[item.row_index][item.col_index];
        else
          res.status = ST_IGNORED;
      end
      default: begin
        res.status = ST_IGNORED;
      end
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Checks each result transfer, then predicts each input transfer.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result read_value %h status %b",
                                    out_data.read_value, out_data.status));
        end else begin
          next_want = pending_results.pop_front();
          if (out_data.read_value !== next_want.read_value)
            report_mismatch($sformatf("read_value got %h expected %h",
                                      out_data.read_value, next_want.read_value));
          if (out_data.status !== next_want.status)
            report_mismatch($sformatf("status got %b expected %b",
                                      out_data.status, next_want.status));
        end
      end
      if (in_valid && !in_stall) begin
        predicted = apply_clock_op(in_data);
        pending_results.push_back(lit_valid ? lit_result : predicted);
      end
      if (cfg_we) begin
        if (cfg_index == CFG_NODE_COUNT)
          node_count_q = cfg_data;
        else
          own_id_q = cfg_data[2:0];
      end
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver back-pressure.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Presents one item at a falling edge and holds it until its transfer.
  task automatic drive_item(in_item_t item, bit use_lit, out_item_t lit);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    lit_valid = use_lit;
    lit_result = lit;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    items_sent++;
  endtask

  // Holds off the sender until every expected result has come.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_cfg(logic sel, logic [3:0] val);
    cfg_we <= 1'b1;
    cfg_index <= sel;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [VAL_W-1:0] rand_clock_value();
    logic [VAL_W-1:0] v;
    case ($urandom_range(3))
      0: v = VAL_W'($urandom_range(40));
      1: v = VAL_MAX - VAL_W'($urandom_range(2));
      default: v = VAL_W'($urandom);
    endcase
    return v;
  endfunction

  // Mostly in range, with an occasional index anywhere in the field.
  function automatic logic [2:0] rand_index(int unsigned n);
    if (n == 0 || $urandom_range(9) == 0) return 3'($urandom_range(7));
    return 3'($urandom_range(n - 1));
  endfunction

  function automatic in_item_t rand_op_item(int unsigned n);
    in_item_t    item;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 18)      item.func = OP_TICK;
    else if (pick < 24) item.func = OP_RESET;
    else if (pick < 36) item.func = OP_SET;
    else if (pick < 70) item.func = OP_MERGE;
    else if (pick < 95) item.func = OP_READ;
    else                item.func = 3'($urandom_range(FUNC_SPARE_5, FUNC_SPARE_7));
    item.row_index = rand_index(n);
    item.col_index = rand_index(n);
    item.value = rand_clock_value();
    if (item.func == OP_MERGE)
      item.last_cell = ($urandom_range(9) == 0);
    else
      item.last_cell = 1'($urandom_range(1));
    return item;
  endfunction

  // Sends a whole received matrix; some sequences break off early or stray out of range.
  task automatic send_merge_matrix(int unsigned n);
    int unsigned k;
    int unsigned last_k;
    bit          broken;
    in_item_t    item;
    broken = ($urandom_range(4) == 0);
    last_k = broken ? $urandom_range(n * n - 1) : n * n - 1;
    for (k = 0; k <= last_k; k++) begin
      item.func = OP_MERGE;
      item.row_index = 3'(k / n);
      item.col_index = 3'(k % n);
      if (broken && $urandom_range(7) == 0) begin
        item.row_index = 3'($urandom_range(7));
        item.col_index = 3'($urandom_range(7));
      end
      item.value = rand_clock_value();
      item.last_cell = (k == last_k);
      drive_item(item, 1'b0, '0);
    end
  endtask

  function automatic stim_row_t op_row(logic [2:0] func, logic [2:0] row, logic [2:0] col,
                                       logic [VAL_W-1:0] value, logic last);
    stim_row_t r;
    r.is_cfg = 1'b0;
    r.cfg_sel = CFG_NODE_COUNT;
    r.cfg_val = '0;
    r.item.func = func;
    r.item.row_index = row;
    r.item.col_index = col;
    r.item.value = value;
    r.item.last_cell = last;
    r.has_lit = 1'b0;
    r.lit = '0;
    return r;
  endfunction

  function automatic stim_row_t with_result(stim_row_t r, logic [VAL_W-1:0] rd, logic st);
    r.has_lit = 1'b1;
    r.lit.read_value = rd;
    r.lit.status = st;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(logic sel, logic [3:0] val);
    stim_row_t r;
    r = op_row(OP_TICK, '0, '0, '0, 1'b0);
    r.is_cfg = 1'b1;
    r.cfg_sel = sel;
    r.cfg_val = val;
    return r;
  endfunction

  initial begin
    stim_row_t   directed_rows[$];
    stim_row_t   row_q;
    int          phase;
    int unsigned n;
    int unsigned budget;
    int unsigned phase_start;
    int unsigned pick;
    logic [3:0]  nc;

    for (int i = 0; i < MAX_NODES; i++)
      for (int j = 0; j < MAX_NODES; j++)
        clock_entries[i][j] = '0;
    node_count_q = NODE_COUNT_RST;
    own_id_q = OWN_ID_RST;

    // Full size, own id zero: reset contents, saturation, merge and fold.
    directed_rows.push_back(with_result(op_row(OP_READ, 3'd0, 3'd0, '0, 1'b0), '0, ST_DONE));
    directed_rows.push_back(with_result(op_row(OP_TICK, 3'd0, 3'd0, '0, 1'b0), '0, ST_DONE));
    directed_rows.push_back(with_result(op_row(OP_READ, 3'd0, 3'd0, '0, 1'b0),
                                        VAL_W'(1), ST_DONE));
    directed_rows.push_back(with_result(op_row(OP_SET, 3'd7, 3'd7, VAL_MAX, 1'b1),
                                        '0, ST_DONE));
    directed_rows.push_back(with_result(op_row(OP_READ, 3'd7, 3'd7, '0, 1'b0),
                                        VAL_MAX, ST_DONE));
    directed_rows.push_back(with_result(op_row(OP_SET, 3'd0, 3'd0, VAL_MAX - 1'b1, 1'b0),
                                        '0, ST_DONE));
    directed_rows.push_back(with_result(op_row(OP_TICK, 3'd0, 3'd0, '0, 1'b0), '0, ST_DONE));
    directed_rows.push_back(with_result(op_row(OP_TICK, 3'd0, 3'd0, '0, 1'b0), '0, ST_DONE));
    directed_rows.push_back(with_result(op_row(OP_READ, 3'd0, 3'd0, '0, 1'b0),
                                        VAL_MAX, ST_DONE));
    directed_rows.push_back(with_result(op_row(OP_MERGE, 3'd2, 3'd5, VAL_W'('h12345678), 1'b0),
                                        '0, ST_DONE));
    directed_rows.push_back(with_result(op_row(OP_MERGE, 3'd7, 3'd1, VAL_W'('h55555555), 1'b1),
                                        '0, ST_DONE));
    directed_rows.push_back(op_row(OP_READ, 3'd0, 3'd5, '0, 1'b0));
    directed_rows.push_back(with_result(op_row(OP_RESET, 3'd7, 3'd0, '0, 1'b0), '0, ST_DONE));
    directed_rows.push_back(with_result(op_row(OP_READ, 3'd7, 3'd7, '0, 1'b0), '0, ST_DONE));
    // Unused function codes are dropped whatever the other fields hold.
    directed_rows.push_back(with_result(op_row(FUNC_SPARE_5, 3'd7, 3'd7, VAL_MAX, 1'b1),
                                        '0, ST_IGNORED));
    directed_rows.push_back(with_result(op_row(FUNC_SPARE_7, 3'd0, 3'd0, '0, 1'b0),
                                        '0, ST_IGNORED));
    // Smaller group: indices past the active square are refused.
    directed_rows.push_back(cfg_row(CFG_NODE_COUNT, 4'd4));
    directed_rows.push_back(with_result(op_row(OP_READ, 3'd4, 3'd0, '0, 1'b0), '0, ST_IGNORED));
    directed_rows.push_back(with_result(op_row(OP_SET, 3'd5, 3'd0, VAL_W'(9), 1'b0),
                                        '0, ST_IGNORED));
    directed_rows.push_back(with_result(op_row(OP_RESET, 3'd6, 3'd0, '0, 1'b0), '0, ST_IGNORED));
    directed_rows.push_back(op_row(OP_MERGE, 3'd5, 3'd0, VAL_W'(3), 1'b1));
    directed_rows.push_back(with_result(op_row(OP_MERGE, 3'd0, 3'd7, VAL_W'(3), 1'b0),
                                        '0, ST_IGNORED));
    // Own id outside the group: ticks and folds are refused.
    directed_rows.push_back(cfg_row(CFG_OWN_ID, 4'd6));
    directed_rows.push_back(with_result(op_row(OP_TICK, 3'd0, 3'd0, '0, 1'b0), '0, ST_IGNORED));
    directed_rows.push_back(with_result(op_row(OP_MERGE, 3'd1, 3'd1, VAL_W'(99), 1'b1),
                                        '0, ST_IGNORED));
    // An empty group refuses everything.
    directed_rows.push_back(cfg_row(CFG_NODE_COUNT, 4'd0));
    directed_rows.push_back(with_result(op_row(OP_READ, 3'd0, 3'd0, '0, 1'b0), '0, ST_IGNORED));
    // A count above the group size clamps to the full matrix.
    directed_rows.push_back(cfg_row(CFG_NODE_COUNT, 4'd15));
    directed_rows.push_back(cfg_row(CFG_OWN_ID, 4'd7));
    directed_rows.push_back(op_row(OP_READ, 3'd7, 3'd7, '0, 1'b0));
    directed_rows.push_back(with_result(op_row(OP_TICK, 3'd0, 3'd0, '0, 1'b0), '0, ST_DONE));
    directed_rows.push_back(op_row(OP_MERGE, 3'd3, 3'd3, '0, 1'b1));
    directed_rows.push_back(op_row(OP_READ, 3'd7, 3'd3, '0, 1'b0));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed table.
    foreach (directed_rows[k]) begin
      row_q = directed_rows[k];
      if (row_q.is_cfg) begin
        drain_results();
        write_cfg(row_q.cfg_sel, row_q.cfg_val);
      end else begin
        drive_item(row_q.item, row_q.has_lit, row_q.lit);
      end
    end

    // Random phases, each with its own register setting and idling mode.
    for (phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase / 4)
        0: begin
          send_idle_pct = 34;
          recv_idle_pct = 75;
        end
        1: begin
          send_idle_pct = 75;
          recv_idle_pct = 34;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      drain_results();
      case (phase % 6)
        0: nc = 4'd8;
        1: nc = 4'd1;
        2: nc = 4'($urandom_range(2, 7));
        3: nc = 4'($urandom_range(9, 15));
        4: nc = 4'd0;
        default: nc = 4'($urandom_range(1, 8));
      endcase
      write_cfg(CFG_NODE_COUNT, nc);
      n = (nc > MAX_NODES) ? MAX_NODES : nc;
      if (n != 0 && $urandom_range(9) != 0)
        write_cfg(CFG_OWN_ID, 4'($urandom_range(n - 1)));
      else
        write_cfg(CFG_OWN_ID, 4'($urandom_range(15)));
      budget = (n == 0) ? EMPTY_PHASE_ITEMS : PHASE_ITEMS;
      phase_start = items_sent;
      while (items_sent - phase_start < budget) begin
        pick = $urandom_range(99);
        if (pick < 12 && n != 0)
          send_merge_matrix(n);
        else if (pick < 14)
          drain_results();
        else
          drive_item(rand_op_item(n), 1'b0, '0);
      end
    end

    drain_results();
    repeat (FINAL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: matrix_logical_clock_core.f
sv/mlc_pkg.sv
sv/mlc_ctrl.sv
sv/mlc_datapath.sv
sv/matrix_logical_clock_core.sv
bench/matrix_logical_clock_core_tb.sv
